// File: rtl/tgcp_pkg.sv
package tgcp_pkg;

  // Store geometry
  localparam int MAX_BOXES  = 8;
  localparam int COORD_BITS = 8;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);

  // Port field widths
  localparam int FIELD_W   = 8;
  localparam int OUT_IDX_W = 3;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  localparam int BOX_W = $bits(box_t);

endpackage

// File: rtl/tgcp_box_if.sv
interface tgcp_box_if;
  logic                         valid;
  logic                         ready;
  logic [tgcp_pkg::FIELD_W-1:0] box_x;
  logic [tgcp_pkg::FIELD_W-1:0] box_y;
  logic [tgcp_pkg::FIELD_W-1:0] box_w;
  logic [tgcp_pkg::FIELD_W-1:0] box_h;
  logic                         last_box;

  modport source (output valid, box_x, box_y, box_w, box_h, last_box, input ready);
  modport sink   (input valid, box_x, box_y, box_w, box_h, last_box, output ready);
endinterface

// File: rtl/tgcp_pair_if.sv
interface tgcp_pair_if;
  logic                           valid;
  logic                           ready;
  logic [tgcp_pkg::OUT_IDX_W-1:0] first_box;
  logic [tgcp_pkg::OUT_IDX_W-1:0] second_box;
  logic                           pair_valid;
  logic                           last_pair;

  modport source (output valid, first_box, second_box, pair_valid, last_pair, input ready);
  modport sink   (input valid, first_box, second_box, pair_valid, last_pair, output ready);
endinterface

// File: rtl/tgcp_ram.sv
module tgcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tile_grid_collision_pairs_core.sv
// Grid broad-phase collision core. Boxes (tile rectangles) arrive one word
// each and are written into an 8-entry box RAM at one word per cycle; a box
// beyond the eighth is dropped. The word flagged last_box closes the frame:
// the core then scans every ordered pair (i, j), i != j, of the N stored
// boxes and sends one result word per pair that shares at least one tile,
// in ascending i then j, the final word flagged last_pair. A frame with no
// colliding pair sends a single word with pair_valid low. While the scan
// runs no box is accepted. The single read port of the box RAM delivers one
// stored box per cycle while the result side does not stall: each row i
// first reads box i, then loads it into the hold register while reading box
// 0, then compares it with each stored box in turn. The result word sits
// in an output register, so the scan keeps running while one result waits.
module tile_grid_collision_pairs_core (
  input  logic               clk,
  input  logic               rst,
  tgcp_box_if.sink           boxes,
  tgcp_pair_if.source        pairs
);

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_RI   = 5'b00010,
    S_RJ   = 5'b00100,
    S_CMP  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [tgcp_pkg::CNT_W-1:0] box_count, box_count_next;
  logic [tgcp_pkg::CNT_W-1:0] i_cnt, i_next;
  logic [tgcp_pkg::CNT_W-1:0] j_cnt, j_next;
  logic [tgcp_pkg::CNT_W-1:0] i_inc, j_inc;

  logic                       in_acc;
  logic                       ram_we;
  logic                       ram_re;
  logic [tgcp_pkg::IDX_W-1:0] ram_raddr;
  logic [tgcp_pkg::BOX_W-1:0] ram_rdata;
  tgcp_pkg::box_t             wr_box;
  tgcp_pkg::box_t             a_box;
  tgcp_pkg::box_t             b_box;
  logic                       a_load;

  logic                       hit;
  logic                       meet_x, meet_y;
  logic                       out_free;
  logic                       stall;

  logic                       pend_valid, pend_valid_next;
  logic [tgcp_pkg::IDX_W-1:0] pend_i, pend_j, pend_i_next, pend_j_next;

  logic                       out_load;
  logic                       out_valid;
  logic [tgcp_pkg::IDX_W-1:0] out_i_next, out_j_next;
  logic                       out_pv_next, out_last_next;
  logic [tgcp_pkg::IDX_W-1:0] out_i, out_j;
  logic                       out_pv, out_last;

  // Input handshake and box write
  assign boxes.ready = (state == S_LOAD);
  assign in_acc      = boxes.valid && boxes.ready;
  assign ram_we      = in_acc && (box_count < tgcp_pkg::CNT_W'(tgcp_pkg::MAX_BOXES));

  assign wr_box.x = tgcp_pkg::COORD_BITS'(boxes.box_x);
  assign wr_box.y = tgcp_pkg::COORD_BITS'(boxes.box_y);
  assign wr_box.w = tgcp_pkg::COORD_BITS'(boxes.box_w);
  assign wr_box.h = tgcp_pkg::COORD_BITS'(boxes.box_h);

  tgcp_ram #(
    .WIDTH (tgcp_pkg::BOX_W),
    .DEPTH (tgcp_pkg::MAX_BOXES)
  ) u_box_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (box_count[tgcp_pkg::IDX_W-1:0]),
    .wdata (wr_box),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign b_box = tgcp_pkg::box_t'(ram_rdata);

  // Hold box i while its row is scanned
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_box <= b_box;
    end
  end

  // Two-dimensional tile overlap, extents taken without wrap
  assign meet_x = ({1'b0, a_box.x} < ({1'b0, b_box.x} + {1'b0, b_box.w})) &&
                  ({1'b0, b_box.x} < ({1'b0, a_box.x} + {1'b0, a_box.w}));
  assign meet_y = ({1'b0, a_box.y} < ({1'b0, b_box.y} + {1'b0, b_box.h})) &&
                  ({1'b0, b_box.y} < ({1'b0, a_box.y} + {1'b0, a_box.h}));
  assign hit = (i_cnt != j_cnt) &&
               (a_box.w != '0) && (a_box.h != '0) &&
               (b_box.w != '0) && (b_box.h != '0) &&
               meet_x && meet_y;

  assign out_free = !out_valid || pairs.ready;
  assign stall    = hit && pend_valid && !out_free;
  assign i_inc    = i_cnt + tgcp_pkg::CNT_W'(1);
  assign j_inc    = j_cnt + tgcp_pkg::CNT_W'(1);

  // Scan sequencer
  always_comb begin
    state_next      = state;
    box_count_next  = box_count;
    i_next          = i_cnt;
    j_next          = j_cnt;
    pend_valid_next = pend_valid;
    pend_i_next     = pend_i;
    pend_j_next     = pend_j;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    a_load          = 1'b0;
    out_load        = 1'b0;
    out_i_next      = pend_i;
    out_j_next      = pend_j;
    out_pv_next     = 1'b1;
    out_last_next   = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (in_acc) begin
          if (ram_we) begin
            box_count_next = box_count + tgcp_pkg::CNT_W'(1);
          end
          if (boxes.last_box) begin
            i_next     = '0;
            state_next = S_RI;
          end
        end
      end
      S_RI: begin
        ram_re     = 1'b1;
        ram_raddr  = i_cnt[tgcp_pkg::IDX_W-1:0];
        state_next = S_RJ;
      end
      S_RJ: begin
        a_load     = 1'b1;
        ram_re     = 1'b1;
        ram_raddr  = '0;
        j_next     = '0;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (!stall) begin
          if (hit) begin
            if (pend_valid) begin
              out_load = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_i_next     = i_cnt[tgcp_pkg::IDX_W-1:0];
            pend_j_next     = j_cnt[tgcp_pkg::IDX_W-1:0];
          end
          if (j_inc < box_count) begin
            j_next    = j_inc;
            ram_re    = 1'b1;
            ram_raddr = j_inc[tgcp_pkg::IDX_W-1:0];
          end else if (i_inc < box_count) begin
            i_next     = i_inc;
            state_next = S_RI;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_last_next   = 1'b1;
          if (!pend_valid) begin
            out_i_next  = '0;
            out_j_next  = '0;
            out_pv_next = 1'b0;
          end
          pend_valid_next = 1'b0;
          box_count_next  = '0;
          state_next      = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      box_count  <= '0;
      i_cnt      <= '0;
      j_cnt      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      box_count  <= box_count_next;
      i_cnt      <= i_next;
      j_cnt      <= j_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Pending pair payload
  always_ff @(posedge clk) begin
    pend_i <= pend_i_next;
    pend_j <= pend_j_next;
  end

  // Output register: load a word, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pairs.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_i    <= out_i_next;
      out_j    <= out_j_next;
      out_pv   <= out_pv_next;
      out_last <= out_last_next;
    end
  end

  assign pairs.valid      = out_valid;
  assign pairs.first_box  = tgcp_pkg::OUT_IDX_W'(out_i);
  assign pairs.second_box = tgcp_pkg::OUT_IDX_W'(out_j);
  assign pairs.pair_valid = out_pv;
  assign pairs.last_pair  = out_last;

  // Checks
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (in_acc && boxes.last_box) |=> !boxes.ready)
    else $error("box accepted right after the last box of a frame");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    box_count <= tgcp_pkg::CNT_W'(tgcp_pkg::MAX_BOXES))
    else $error("box count above store depth");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_pv) |-> out_last)
    else $error("empty report not flagged last");

  a_no_pend_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> !pend_valid)
    else $error("pending pair left over into box loading");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ((i_cnt < box_count) && (j_cnt < box_count)))
    else $error("scan index outside stored boxes");

endmodule
